// File: sv/daf_pkg.sv
// ----------------------------------------------------------------------------
// daf_pkg
// Shared widths and types of the distributed arithmetic FIR filter.
// ----------------------------------------------------------------------------
package daf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int OUT_W     = 20;
  localparam int NUM_COEF  = 8;
  localparam int CFG_IDX_W = 3;
  // adder tree over the padded tap set
  localparam int TREE_N    = 8;
  localparam int PAIR_W    = COEF_W + 1;
  localparam int QUAD_W    = COEF_W + 2;
  localparam int TERM_W    = COEF_W + 3;
  localparam int ACC_W     = OUT_W + 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [OUT_W-1:0]    result_t;
  typedef logic signed [PAIR_W-1:0]   pair_t;
  typedef logic signed [QUAD_W-1:0]   quad_t;
  typedef logic signed [TERM_W-1:0]   term_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

endpackage

// File: sv/daf_in_if.sv
// ----------------------------------------------------------------------------
// daf_in_if
// Sample channel: valid/ready handshake carrying one input sample.
// ----------------------------------------------------------------------------
interface daf_in_if
  import daf_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// File: sv/daf_out_if.sv
// ----------------------------------------------------------------------------
// daf_out_if
// Result channel: valid/ready handshake carrying one filtered output.
// ----------------------------------------------------------------------------
interface daf_out_if
  import daf_pkg::*;
;
  logic    valid;
  logic    ready;
  result_t filtered_out;

  modport source (output valid, output filtered_out, input ready);
  modport sink   (input valid, input filtered_out, output ready);
endinterface

// File: sv/distributed_arithmetic_fir.sv
// ----------------------------------------------------------------------------
// distributed_arithmetic_fir
// Bit-serial distributed arithmetic FIR filter with writable coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one signed sample per item; it enters a TAPS deep delay line.
//   out_ch : one filtered result per item, sum of coefficient times delayed
//            sample, arithmetically shifted right by FRAC_BITS.
//   cfg_*  : write coefficient cfg_index with cfg_data while the filter idles.
// Timing:
//   The delay line is read one bit plane per cycle, LSB first, FRAC_BITS + 1
//   planes in all, and each plane's subset sum goes through a two-stage
//   registered adder tree before it is accumulated. A new item is accepted
//   once the previous one has left the accumulator, even while its result
//   still waits on out_ch; no new item is taken while one is being summed.
// Reset:
//   Coefficients and the delay line clear to zero; no result is pending.
// Back-pressure:
//   The result register holds while out_ch.ready is low; a finished sum then
//   waits in the accumulator and in_ch.ready stays low until it moves on.
// ----------------------------------------------------------------------------
module distributed_arithmetic_fir
  import daf_pkg::*;
#(
  parameter int TAPS      = 8,
  parameter int FRAC_BITS = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  daf_in_if.sink               in_ch,
  daf_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] LastPlane = CNT_W'(FRAC_BITS);

  coef_t   coef_r  [TAPS];
  sample_t line_r  [TAPS];
  sample_t work_r  [TAPS];

  logic             busy_r;
  logic             issue_r;
  logic [CNT_W-1:0] plane_r;

  logic             s1_valid_r, s1_sign_r;
  pair_t            pair_r [TREE_N/2];
  logic             s2_valid_r, s2_sign_r;
  quad_t            quad_r [TREE_N/4];

  acc_t             acc_r, acc_nxt;
  logic             done_r, done_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_data_r, out_data_nxt;
  logic             busy_nxt;

  logic             accept;
  logic             out_free;
  coef_t            masked [TREE_N];
  term_t            term;
  acc_t             term_ext;
  acc_t             sum_bit;
  acc_t             final_sum;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !busy_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.filtered_out = out_data_r;
  assign out_free     = !out_valid_r || out_ch.ready;

  // coefficient registers; indexes at or above TAPS act as zero weights
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < TAPS; n++) coef_r[n] <= '0;
    end else if (cfg_we) begin
      for (int n = 0; n < TAPS; n++) begin
        if (32'(cfg_index) == n) coef_r[n] <= coef_t'(cfg_data);
      end
    end
  end

  // delay line and its serial working copy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < TAPS; n++) line_r[n] <= '0;
    end else if (accept) begin
      line_r[0] <= in_ch.sample_in;
      for (int n = 1; n < TAPS; n++) line_r[n] <= line_r[n-1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work_r[0] <= in_ch.sample_in;
      for (int n = 1; n < TAPS; n++) work_r[n] <= line_r[n-1];
    end else if (issue_r) begin
      // arithmetic shift keeps feeding the sign bit above bit 15
      for (int n = 0; n < TAPS; n++) work_r[n] <= work_r[n] >>> 1;
    end
  end

  // bit-plane sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      plane_r <= '0;
    end else if (accept) begin
      issue_r <= 1'b1;
      plane_r <= '0;
    end else if (issue_r) begin
      if (plane_r == LastPlane) begin
        issue_r <= 1'b0;
      end else begin
        plane_r <= plane_r + 1'b1;
      end
    end
  end

  // select the coefficients addressed by the current bit plane
  always_comb begin
    for (int n = 0; n < TREE_N; n++) masked[n] = '0;
    for (int n = 0; n < TAPS; n++) begin
      masked[n] = work_r[n][0] ? coef_r[n] : '0;
    end
  end

  // registered subset-sum tree
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue_r;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_sign_r <= (plane_r == LastPlane);
    s2_sign_r <= s1_sign_r;
    for (int k = 0; k < TREE_N/2; k++) begin
      pair_r[k] <= PAIR_W'(masked[2*k]) + PAIR_W'(masked[2*k+1]);
    end
    for (int k = 0; k < TREE_N/4; k++) begin
      quad_r[k] <= QUAD_W'(pair_r[2*k]) + QUAD_W'(pair_r[2*k+1]);
    end
  end

  assign term      = TERM_W'(quad_r[0]) + TERM_W'(quad_r[1]);
  assign term_ext  = ACC_W'(term);
  assign sum_bit   = acc_r + term_ext;
  // the sign plane is subtracted at full weight, no shift
  assign final_sum = acc_r - term_ext;

  // accumulate: LSB first, shift right after each magnitude plane
  always_comb begin
    acc_nxt       = acc_r;
    done_nxt      = done_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    if (accept) begin
      acc_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (s2_valid_r) begin
      if (s2_sign_r) begin
        if (out_free) begin
          out_data_nxt  = OUT_W'(final_sum);
          out_valid_nxt = 1'b1;
          busy_nxt      = 1'b0;
        end else begin
          acc_nxt  = final_sum;
          done_nxt = 1'b1;
        end
      end else begin
        acc_nxt = sum_bit >>> 1;
      end
    end else if (done_r && out_free) begin
      // drain the held sum once the result register frees up
      out_data_nxt  = OUT_W'(acc_r);
      out_valid_nxt = 1'b1;
      done_nxt      = 1'b0;
      busy_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the distributed arithmetic FIR filter against a direct multiply and
// accumulate over its own delay line, under random stalls on both channels
// and across several coefficient sets written between phases.
// ----------------------------------------------------------------------------
module testbench;
  import daf_pkg::*;

  localparam int TAPS          = 8;
  localparam int FRAC_BITS     = 15;
  localparam int LATENCY       = FRAC_BITS + 4;
  localparam int QUIET_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_ITEMS   = 100;

  typedef enum int {
    SET_RANDOM, SET_EXTREMES, SET_SINGLE_TAP, SET_ALL_MAX, SET_ALL_MIN, SET_SMALL
  } coef_set_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  daf_in_if  in_ch ();
  daf_out_if out_ch ();

  distributed_arithmetic_fir #(
    .TAPS      (TAPS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  coef_t   tap_coefs [NUM_COEF];
  sample_t sample_history [NUM_COEF];
  result_t expected_outputs [$];
  int      error_count = 0;
  int      quiet_cycles = 0;
  bit      throttle_inputs = 1'b0;
  bit      throttle_outputs = 1'b0;
  int      out_stall_left = 0;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic result_t predict_filter_output();
    longint acc;
    longint x;
    longint shifted;
    acc = 0;
    for (int n = 0; n < TAPS; n++) begin
      x = longint'(sample_history[n]);
      // narrower formats keep only the low FRAC_BITS+1 bits, sign at the top
      if (FRAC_BITS < 15) x = (x <<< (63 - FRAC_BITS)) >>> (63 - FRAC_BITS);
      acc += longint'(tap_coefs[n]) * x;
    end
    shifted = acc >>> FRAC_BITS;
    return shifted[OUT_W-1:0];
  endfunction

  task automatic send_sample(input sample_t s);
    int gap;
    gap = (throttle_inputs && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    do @(posedge clk); while (!in_ch.ready);
    for (int n = NUM_COEF - 1; n > 0; n--) sample_history[n] = sample_history[n-1];
    sample_history[0] = s;
    expected_outputs.push_back(predict_filter_output());
  endtask

  // Drop valid and let every pending result drain before touching registers.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_coefficient(input int idx, input coef_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tap_coefs[idx] = value;
  endtask

  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return sample_t'(16'sh8000);
    if (r < 8) return sample_t'(16'sh7FFF);
    if (r < 10) return '0;
    if (r < 12) return sample_t'(-1);
    if (r < 14) return sample_t'(1);
    return sample_t'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic load_coef_set(input coef_set_e kind);
    int    hot;
    coef_t value;
    hot = $urandom_range(0, NUM_COEF - 1);
    wait_idle();
    for (int i = 0; i < NUM_COEF; i++) begin
      case (kind)
        SET_RANDOM:     value = coef_t'($urandom_range(0, 16'hFFFF));
        SET_EXTREMES: begin
          case ($urandom_range(0, 2))
            0:       value = coef_t'(16'sh8000);
            1:       value = coef_t'(16'sh7FFF);
            default: value = '0;
          endcase
        end
        SET_SINGLE_TAP: value = (i == hot) ? coef_t'($urandom_range(0, 16'hFFFF)) : '0;
        SET_ALL_MAX:    value = coef_t'(16'sh7FFF);
        SET_ALL_MIN:    value = coef_t'(16'sh8000);
        default:        value = coef_t'($urandom_range(0, 15)) - coef_t'(8);
      endcase
      write_coefficient(i, value);
    end
  endtask

  // Coefficients reset to zero, so every output is zero whatever the input.
  task automatic test_after_reset();
    send_sample(sample_t'(16'sh7FFF));
    send_sample(sample_t'(16'sh8000));
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
  endtask

  // A full-scale negative impulse walks -coefficient out of every tap.
  task automatic test_impulse_response();
    wait_idle();
    write_coefficient(0, coef_t'(16'sh8000));
    write_coefficient(1, coef_t'(16'sh7FFF));
    write_coefficient(2, coef_t'(-1));
    write_coefficient(3, coef_t'(1));
    write_coefficient(4, coef_t'(16'sh1234));
    write_coefficient(5, coef_t'(-16'sh0F0F));
    write_coefficient(6, coef_t'(16'sh5555));
    write_coefficient(7, coef_t'(-16'sh2AAA));
    send_sample(sample_t'(16'sh8000));
    for (int i = 0; i < NUM_COEF - 1; i++) send_sample('0);
    send_sample(sample_t'(16'sh7FFF));
    // a unit sample against the negative weight at tap 0 gives -1 on its own
    send_sample(sample_t'(1));
  endtask

  // All weights and samples at the negative limit give the largest output.
  task automatic test_full_scale();
    wait_idle();
    for (int i = 0; i < NUM_COEF; i++) write_coefficient(i, coef_t'(16'sh8000));
    for (int i = 0; i < NUM_COEF; i++) send_sample(sample_t'(16'sh8000));
    send_sample(sample_t'(16'sh7FFF));
    send_sample(sample_t'(16'sh7FFF));
  endtask

  task automatic test_random_streams();
    coef_set_e kind;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      kind = coef_set_e'(p % 6);
      load_coef_set(kind);
      // every third phase runs flat out on both sides
      throttle_inputs  = (p % 3 != 2);
      throttle_outputs = (p % 3 != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(pick_sample());
    end
    throttle_inputs  = 1'b0;
    throttle_outputs = 1'b0;
  endtask

  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_stall_left <= out_stall_left - 1;
      out_ch.ready   <= 1'b0;
    end else if (throttle_outputs && $urandom_range(0, 99) < 25) begin
      out_stall_left <= pick_gap() - 1;
      out_ch.ready   <= 1'b0;
    end else begin
      out_ch.ready   <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_outputs.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected output: filtered_out=%0d", out_ch.filtered_out);
      end else begin
        want = expected_outputs.pop_front();
        if (out_ch.filtered_out !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("filtered_out mismatch: expected %0d, got %0d",
                     want, out_ch.filtered_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    out_ch.ready    = 1'b0;
    for (int i = 0; i < NUM_COEF; i++) begin
      tap_coefs[i]      = '0;
      sample_history[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_impulse_response();
    test_full_scale();
    test_random_streams();

    wait_idle();
    repeat (LATENCY) @(negedge clk);
    if (error_count == 0 && expected_outputs.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
